@@ rtl/pnm_binary_stream_parser_defines.svh @@
// Assertion macros for the PNM binary stream parser.
`ifndef PNM_BINARY_STREAM_PARSER_DEFINES_SVH
`define PNM_BINARY_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PNM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PNM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/pnm_pkg.sv @@
// Shared constants, codes and types of the PNM binary stream parser.
package pnm_pkg;

   // Largest accepted width or height.
   localparam int unsigned MAX_DIMENSION = 65535;
   localparam int unsigned DIM_LIMIT     = (MAX_DIMENSION > 65535) ? 65535 : MAX_DIMENSION;

   // A digit arriving while the accumulator is at or above this value overflows it.
   localparam logic [30:0] ACC_OVF_LIMIT = 31'd214748364;

   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_5     = 8'h35;
   localparam logic [7:0] CH_6     = 8'h36;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_MAGIC     = 3'd0;
   localparam logic [2:0] ERR_NO_DIGITS = 3'd1;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
   localparam logic [2:0] ERR_RANGE     = 3'd3;
   localparam logic [2:0] ERR_SEPARATOR = 3'd4;
   localparam logic [2:0] ERR_EARLY_END = 3'd5;
   localparam logic [2:0] ERR_PIXEL     = 3'd6;

   typedef struct packed {
      logic        is_digit;
      logic        overflow;
      logic [30:0] acc_next;
   } digit_status_type;

   typedef struct packed {
      logic        hold;      // first byte of a two-byte sample
      logic        bad;       // sample above maxval
      logic [15:0] value;
      logic        last;      // last component of last column
      logic [1:0]  comp_next;
      logic [15:0] col_next;
      logic [15:0] row_next;
      logic        done;      // last sample of the image
   } pix_status_type;

endpackage

@@ rtl/pnm_digit_acc.sv @@
// Decimal digit detect and accumulate-by-ten with overflow check.
module pnm_digit_acc (
   input  logic [7:0]                ch,
   input  logic                      is_end,
   input  logic [30:0]               acc,
   output pnm_pkg::digit_status_type status
);
   import pnm_pkg::*;

   logic [7:0] digit;

   assign digit = ch - CH_0;

   always_comb begin
      status.is_digit = !is_end && (ch >= CH_0) && (ch <= CH_9);
      status.overflow = acc >= ACC_OVF_LIMIT;
      // acc * 10 as shift-add
      status.acc_next = (acc << 3) + (acc << 1) + {27'd0, digit[3:0]};
   end

endmodule

@@ rtl/pnm_pixel_unit.sv @@
// Sample assembly, range check and position advance for the pixel section.
module pnm_pixel_unit (
   input  logic [7:0]              data,
   input  logic [7:0]              hold_byte,
   input  logic                    byte_phase,
   input  logic [15:0]             maxval,
   input  logic [1:0]              components,
   input  logic [15:0]             width,
   input  logic [15:0]             height,
   input  logic [1:0]              comp,
   input  logic [15:0]             col,
   input  logic [15:0]             row,
   output pnm_pkg::pix_status_type status
);
   import pnm_pkg::*;

   logic        wide;
   logic [2:0]  comp_p1;
   logic [16:0] col_p1;
   logic [16:0] row_p1;
   logic        comp_wrap;
   logic        col_wrap;

   assign wide      = |maxval[15:8];
   assign comp_p1   = {1'b0, comp} + 3'd1;
   assign col_p1    = {1'b0, col} + 17'd1;
   assign row_p1    = {1'b0, row} + 17'd1;
   assign comp_wrap = comp_p1 >= {1'b0, components};
   assign col_wrap  = col_p1 >= {1'b0, width};

   always_comb begin
      status.hold      = wide && !byte_phase;
      status.value     = wide ? {hold_byte, data} : {8'd0, data};
      status.bad       = status.value > maxval;
      status.last      = (comp_p1 == {1'b0, components}) && (col_p1 == {1'b0, width});
      status.comp_next = comp_wrap ? 2'd0 : comp_p1[1:0];
      status.col_next  = comp_wrap ? (col_wrap ? 16'd0 : col_p1[15:0]) : col;
      status.row_next  = (comp_wrap && col_wrap) ? row_p1[15:0] : row;
      status.done      = comp_wrap && col_wrap && (row_p1 >= {1'b0, height});
   end

endmodule

@@ rtl/pnm_binary_stream_parser.sv @@
// Top level of the PNM binary stream parser (P5 grey / P6 colour).
// Takes a binary PGM or PPM file one byte per req transaction (req_end_of_stream marks
// the end of the stream) and returns at most one rsp transaction per byte: a header
// result once width, height and maxval are parsed, then one sample result per pixel
// component, or a single error result, after which the block stays silent until
// reset. Bytes after the last row are ignored. Throughput is one byte per clock
// cycle while the rsp channel is not stalled; a byte passes through the input
// register, then the result register. The rate is set by the parser step that
// closes the loop through the phase register and the 31-bit decimal accumulator. A
// stalled rsp channel holds the result register; one further byte waits in the input
// register, and req_ready drops only when both are full and rsp_ready is low.
`include "pnm_binary_stream_parser_defines.svh"

module pnm_binary_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_sample_value,
   output logic [1:0]  rsp_component_index,
   output logic [15:0] rsp_column,
   output logic [15:0] rsp_row,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [15:0] rsp_max_value,
   output logic [1:0]  rsp_component_count,
   output logic        rsp_end_of_line,
   output logic [2:0]  rsp_error_code
);
   import pnm_pkg::*;

   // Parser phases. The separator after maxval is resolved in the same step
   // that ends maxval, so it never rests in a phase of its own.
   localparam logic [3:0] PH_MAGIC_P    = 4'd0;
   localparam logic [3:0] PH_MAGIC_NUM  = 4'd1;
   localparam logic [3:0] PH_SC_BLANK   = 4'd2;
   localparam logic [3:0] PH_SC_HASH    = 4'd3;
   localparam logic [3:0] PH_COMMENT    = 4'd4;
   localparam logic [3:0] PH_NUM_LEAD   = 4'd5;
   localparam logic [3:0] PH_NUM_SIGNED = 4'd6;
   localparam logic [3:0] PH_NUM_DIGITS = 4'd7;
   localparam logic [3:0] PH_CRLF       = 4'd8;
   localparam logic [3:0] PH_PIXEL      = 4'd9;
   localparam logic [3:0] PH_DONE       = 4'd10;

   // ---------------- input register ----------------
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       adv;

   // ---------------- parser state ----------------
   logic [3:0]  phase_ff, phase_in;
   logic [30:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        seen_ff, seen_in;
   logic [1:0]  idx_ff, idx_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [15:0] maxval_ff, maxval_in;
   logic [1:0]  ncomp_ff, ncomp_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [1:0]  comp_ff, comp_in;
   logic [7:0]  hold_ff, hold_in;
   logic        bphase_ff, bphase_in;
   logic        err_ff, err_in;

   // ---------------- result register ----------------
   logic        rsp_valid_ff;
   logic [1:0]  rsp_result_kind_ff, rsp_result_kind_in;
   logic [15:0] rsp_sample_value_ff, rsp_sample_value_in;
   logic [1:0]  rsp_component_index_ff, rsp_component_index_in;
   logic [15:0] rsp_column_ff, rsp_column_in;
   logic [15:0] rsp_row_ff, rsp_row_in;
   logic [15:0] rsp_image_width_ff, rsp_image_width_in;
   logic [15:0] rsp_image_height_ff, rsp_image_height_in;
   logic [15:0] rsp_max_value_ff, rsp_max_value_in;
   logic [1:0]  rsp_component_count_ff, rsp_component_count_in;
   logic        rsp_end_of_line_ff, rsp_end_of_line_in;
   logic [2:0]  rsp_error_code_ff, rsp_error_code_in;
   logic        emit;

   // ---------------- byte classes ----------------
   logic m_sp, m_tab, m_lf, m_cr, m_blank, m_plus, m_minus, m_sign, m_hash;
   logic [30:0] acc_sel;
   digit_status_type dig;
   pix_status_type   pix;

   // step-local path flags
   logic fresh, dstep, sc2, sep, pix_go;
   logic [15:0] dim_chk;

   assign adv       = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || adv;

   assign m_sp    = !in_end_ff && (in_byte_ff == CH_SP);
   assign m_tab   = !in_end_ff && (in_byte_ff == CH_TAB);
   assign m_lf    = !in_end_ff && (in_byte_ff == CH_LF);
   assign m_cr    = !in_end_ff && (in_byte_ff == CH_CR);
   assign m_blank = m_sp || m_tab || m_lf || m_cr;
   assign m_plus  = !in_end_ff && (in_byte_ff == CH_PLUS);
   assign m_minus = !in_end_ff && (in_byte_ff == CH_MINUS);
   assign m_sign  = m_plus || m_minus;
   assign m_hash  = !in_end_ff && (in_byte_ff == CH_HASH);

   // Only an ongoing number feeds the accumulator; any other entry starts from zero.
   assign acc_sel = (phase_ff == PH_NUM_DIGITS) ? acc_ff : 31'd0;

   pnm_digit_acc u_digit (
      .ch     (in_byte_ff),
      .is_end (in_end_ff),
      .acc    (acc_sel),
      .status (dig)
   );

   pnm_pixel_unit u_pixel (
      .data       (in_byte_ff),
      .hold_byte  (hold_ff),
      .byte_phase (bphase_ff),
      .maxval     (maxval_ff),
      .components (ncomp_ff),
      .width      (width_ff),
      .height     (height_ff),
      .comp       (comp_ff),
      .col        (col_ff),
      .row        (row_ff),
      .status     (pix)
   );

   // Checked dimension of the number just ended: zero when out of range.
   assign dim_chk = (!neg_ff && (acc_ff != 31'd0) && ({1'b0, acc_ff} <= 32'(DIM_LIMIT)))
                    ? acc_ff[15:0] : 16'd0;

   // One parser step per byte. The flags chain the hand-offs between phases
   // that happen within a single byte.
   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      seen_in   = seen_ff;
      idx_in    = idx_ff;
      width_in  = width_ff;
      height_in = height_ff;
      maxval_in = maxval_ff;
      ncomp_in  = ncomp_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      comp_in   = comp_ff;
      hold_in   = hold_ff;
      bphase_in = bphase_ff;
      err_in    = err_ff;

      emit                   = 1'b0;
      rsp_result_kind_in     = KIND_HEADER;
      rsp_sample_value_in    = 16'd0;
      rsp_component_index_in = 2'd0;
      rsp_column_in          = 16'd0;
      rsp_row_in             = 16'd0;
      rsp_image_width_in     = 16'd0;
      rsp_image_height_in    = 16'd0;
      rsp_max_value_in       = 16'd0;
      rsp_component_count_in = 2'd0;
      rsp_end_of_line_in     = 1'b0;
      rsp_error_code_in      = ERR_MAGIC;

      fresh  = 1'b0;
      dstep  = 1'b0;
      sc2    = 1'b0;
      sep    = 1'b0;
      pix_go = 1'b0;

      if (!err_ff) begin
         case (phase_ff)
            PH_MAGIC_P: begin
               if (!in_end_ff && (in_byte_ff == CH_P)) begin
                  phase_in = PH_MAGIC_NUM;
               end else begin
                  err_in            = 1'b1;
                  emit              = 1'b1;
                  rsp_result_kind_in = KIND_ERROR;
                  rsp_error_code_in = ERR_MAGIC;
               end
            end
            PH_MAGIC_NUM: begin
               if (!in_end_ff && (in_byte_ff == CH_6)) begin
                  ncomp_in = 2'd3;
                  idx_in   = 2'd0;
                  phase_in = PH_SC_BLANK;
               end else if (!in_end_ff && (in_byte_ff == CH_5)) begin
                  ncomp_in = 2'd1;
                  idx_in   = 2'd0;
                  phase_in = PH_SC_BLANK;
               end else begin
                  err_in             = 1'b1;
                  emit               = 1'b1;
                  rsp_result_kind_in = KIND_ERROR;
                  rsp_error_code_in  = ERR_MAGIC;
               end
            end
            PH_SC_BLANK: begin
               if (m_lf) begin
                  phase_in = PH_SC_HASH;
               end else if (!(m_sp || m_tab || m_cr)) begin
                  fresh = 1'b1;
               end
            end
            PH_SC_HASH: begin
               if (m_hash) begin
                  phase_in = PH_COMMENT;
               end else begin
                  fresh = 1'b1;
               end
            end
            PH_COMMENT: begin
               if (m_lf || m_cr) begin
                  phase_in = PH_SC_HASH;
               end else if (in_end_ff) begin
                  fresh = 1'b1;
               end
            end
            PH_NUM_LEAD: begin
               if (m_sign) begin
                  neg_in   = m_minus;
                  phase_in = PH_NUM_SIGNED;
               end else if (!m_blank) begin
                  dstep = 1'b1;
               end
            end
            PH_NUM_SIGNED: begin
               if (!m_blank) begin
                  dstep = 1'b1;
               end
            end
            PH_NUM_DIGITS: begin
               dstep = 1'b1;
            end
            PH_CRLF: begin
               phase_in = PH_PIXEL;
               if (!m_lf) begin
                  pix_go = 1'b1;
               end
            end
            PH_PIXEL: begin
               pix_go = 1'b1;
            end
            default: begin
               // done: ignore everything
            end
         endcase

         // start of a new number
         if (fresh) begin
            acc_in  = 31'd0;
            neg_in  = 1'b0;
            seen_in = 1'b0;
            if (m_blank) begin
               phase_in = PH_NUM_LEAD;
            end else if (m_sign) begin
               neg_in   = m_minus;
               phase_in = PH_NUM_SIGNED;
            end else begin
               dstep = 1'b1;
            end
         end

         // digit or end of number
         if (dstep) begin
            if (dig.is_digit) begin
               if (dig.overflow) begin
                  err_in             = 1'b1;
                  emit               = 1'b1;
                  rsp_result_kind_in = KIND_ERROR;
                  rsp_error_code_in  = ERR_OVERFLOW;
               end else begin
                  acc_in   = dig.acc_next;
                  seen_in  = 1'b1;
                  phase_in = PH_NUM_DIGITS;
               end
            end else if (!seen_in) begin
               err_in             = 1'b1;
               emit               = 1'b1;
               rsp_result_kind_in = KIND_ERROR;
               rsp_error_code_in  = ERR_NO_DIGITS;
            end else begin
               case (idx_ff)
                  2'd0: begin
                     width_in = dim_chk;
                     idx_in   = 2'd1;
                     sc2      = 1'b1;
                  end
                  2'd1: begin
                     height_in = dim_chk;
                     idx_in    = 2'd2;
                     sc2       = 1'b1;
                  end
                  default: begin
                     maxval_in = (!neg_ff && (acc_ff != 31'd0) && (acc_ff[30:16] == 15'd0))
                                 ? acc_ff[15:0] : 16'd0;
                     if ((width_ff == 16'd0) || (height_ff == 16'd0) ||
                         (maxval_in == 16'd0)) begin
                        err_in             = 1'b1;
                        emit               = 1'b1;
                        rsp_result_kind_in = KIND_ERROR;
                        rsp_error_code_in  = ERR_RANGE;
                     end else begin
                        sep = 1'b1;
                     end
                  end
               endcase
            end
         end

         // byte that ended width or height, seen as blank-skip input
         if (sc2) begin
            if (m_sp || m_tab || m_cr) begin
               phase_in = PH_SC_BLANK;
            end else if (m_lf) begin
               phase_in = PH_SC_HASH;
            end else begin
               acc_in  = 31'd0;
               seen_in = 1'b0;
               neg_in  = 1'b0;
               if (m_sign) begin
                  neg_in   = m_minus;
                  phase_in = PH_NUM_SIGNED;
               end else begin
                  err_in             = 1'b1;
                  emit               = 1'b1;
                  rsp_result_kind_in = KIND_ERROR;
                  rsp_error_code_in  = ERR_NO_DIGITS;
               end
            end
         end

         // separator after maxval; CR may pair with a following LF
         if (sep) begin
            if (m_sp || m_lf || m_tab || m_cr) begin
               phase_in               = m_cr ? PH_CRLF : PH_PIXEL;
               emit                   = 1'b1;
               rsp_result_kind_in     = KIND_HEADER;
               rsp_image_width_in     = width_ff;
               rsp_image_height_in    = height_ff;
               rsp_max_value_in       = maxval_in;
               rsp_component_count_in = ncomp_ff;
            end else begin
               err_in             = 1'b1;
               emit               = 1'b1;
               rsp_result_kind_in = KIND_ERROR;
               rsp_error_code_in  = ERR_SEPARATOR;
            end
         end

         if (pix_go) begin
            if (in_end_ff) begin
               err_in             = 1'b1;
               emit               = 1'b1;
               rsp_result_kind_in = KIND_ERROR;
               rsp_error_code_in  = ERR_EARLY_END;
            end else if (pix.hold) begin
               hold_in   = in_byte_ff;
               bphase_in = 1'b1;
            end else begin
               bphase_in = 1'b0;
               if (pix.bad) begin
                  err_in             = 1'b1;
                  emit               = 1'b1;
                  rsp_result_kind_in = KIND_ERROR;
                  rsp_error_code_in  = ERR_PIXEL;
               end else begin
                  emit                   = 1'b1;
                  rsp_result_kind_in     = KIND_SAMPLE;
                  rsp_sample_value_in    = pix.value;
                  rsp_component_index_in = comp_ff;
                  rsp_column_in          = col_ff;
                  rsp_row_in             = row_ff;
                  rsp_end_of_line_in     = pix.last;
                  comp_in                = pix.comp_next;
                  col_in                 = pix.col_next;
                  row_in                 = pix.row_next;
                  if (pix.done) begin
                     phase_in = PH_DONE;
                  end
               end
            end
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (adv) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_end_of_stream;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC_P;
         idx_ff    <= 2'd0;
         col_ff    <= 16'd0;
         row_ff    <= 16'd0;
         comp_ff   <= 2'd0;
         bphase_ff <= 1'b0;
         err_ff    <= 1'b0;
      end else if (adv) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         comp_ff   <= comp_in;
         bphase_ff <= bphase_in;
         err_ff    <= err_in;
      end
      if (adv) begin
         acc_ff    <= acc_in;
         neg_ff    <= neg_in;
         seen_ff   <= seen_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         maxval_ff <= maxval_in;
         ncomp_ff  <= ncomp_in;
         hold_ff   <= hold_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (adv && emit) begin
         rsp_result_kind_ff     <= rsp_result_kind_in;
         rsp_sample_value_ff    <= rsp_sample_value_in;
         rsp_component_index_ff <= rsp_component_index_in;
         rsp_column_ff          <= rsp_column_in;
         rsp_row_ff             <= rsp_row_in;
         rsp_image_width_ff     <= rsp_image_width_in;
         rsp_image_height_ff    <= rsp_image_height_in;
         rsp_max_value_ff       <= rsp_max_value_in;
         rsp_component_count_ff <= rsp_component_count_in;
         rsp_end_of_line_ff     <= rsp_end_of_line_in;
         rsp_error_code_ff      <= rsp_error_code_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_result_kind_ff;
   assign rsp_sample_value    = rsp_sample_value_ff;
   assign rsp_component_index = rsp_component_index_ff;
   assign rsp_column          = rsp_column_ff;
   assign rsp_row             = rsp_row_ff;
   assign rsp_image_width     = rsp_image_width_ff;
   assign rsp_image_height    = rsp_image_height_ff;
   assign rsp_max_value       = rsp_max_value_ff;
   assign rsp_component_count = rsp_component_count_ff;
   assign rsp_end_of_line     = rsp_end_of_line_ff;
   assign rsp_error_code      = rsp_error_code_ff;

   // ---------------- assertions ----------------
   // once the error transaction has drained, nothing else comes out
   `PNM_ASSERT_NEXT(a_err_silent, clock, reset, err_ff && !rsp_valid_ff, !rsp_valid_ff, "result after error")
   // every delivered sample respects the parsed maxval
   `PNM_ASSERT_IMPLY(a_sample_range, clock, reset, rsp_valid_ff && (rsp_result_kind_ff == KIND_SAMPLE), rsp_sample_value_ff <= maxval_ff, "sample above maxval")
   // sample column stays inside the image
   `PNM_ASSERT_IMPLY(a_col_range, clock, reset, rsp_valid_ff && (rsp_result_kind_ff == KIND_SAMPLE), rsp_column_ff < width_ff, "column beyond width")
   // header carries a grey or colour component count
   `PNM_ASSERT_IMPLY(a_hdr_comp, clock, reset, rsp_valid_ff && (rsp_result_kind_ff == KIND_HEADER), (rsp_component_count_ff == 2'd1) || (rsp_component_count_ff == 2'd3), "bad component count")

endmodule

@@ tb/sv/pnm_binary_stream_parser_test.sv @@
// Self-checking testbench for the PNM binary stream parser: one P5/P6 stream, predicted byte by byte.
module pnm_binary_stream_parser_test;
   import pnm_pkg::*;

   // Generous bound: ~1600 transactions, each with random idling on both sides.
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PIXEL_BYTE_BUDGET = 1400;
   localparam int unsigned CALM_TAIL = 150;   // final samples sent without any idling
   localparam int CH_EOS = 256;              // stream-end marker, outside the byte range

   // Parser phases as tracked by the predictor.
   typedef enum logic [3:0] {
      ST_MAGIC_P, ST_MAGIC_DIGIT, ST_GAP_BLANK, ST_GAP_HASH, ST_COMMENT, ST_NUM_LEAD,
      ST_NUM_SIGN, ST_NUM_DIGITS, ST_SEPARATOR, ST_CRLF, ST_SAMPLES, ST_DONE
   } parse_state_e;

   typedef enum logic [1:0] {END_COMPLETE, END_EARLY, END_BAD_PIXEL} stream_end_e;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] sample;
      logic [1:0]  comp;
      logic [15:0] col;
      logic [15:0] row;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] maxv;
      logic [1:0]  ncomp;
      logic        eol;
      logic [2:0]  code;
   } parse_result_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_end_of_stream;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_result_kind;
   logic [15:0] rsp_sample_value;
   logic [1:0]  rsp_component_index;
   logic [15:0] rsp_column;
   logic [15:0] rsp_row;
   logic [15:0] rsp_image_width;
   logic [15:0] rsp_image_height;
   logic [15:0] rsp_max_value;
   logic [1:0]  rsp_component_count;
   logic        rsp_end_of_line;
   logic [2:0]  rsp_error_code;

   pnm_binary_stream_parser uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data_byte       (req_data_byte),
      .req_end_of_stream   (req_end_of_stream),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_sample_value    (rsp_sample_value),
      .rsp_component_index (rsp_component_index),
      .rsp_column          (rsp_column),
      .rsp_row             (rsp_row),
      .rsp_image_width     (rsp_image_width),
      .rsp_image_height    (rsp_image_height),
      .rsp_max_value       (rsp_max_value),
      .rsp_component_count (rsp_component_count),
      .rsp_end_of_line     (rsp_end_of_line),
      .rsp_error_code      (rsp_error_code)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // ---------------------------------------------------------------------------
   // Parser shadow state. The block holds exactly one stream per reset, so this
   // state only ever moves forward: header, samples, then done or stuck error.
   // ---------------------------------------------------------------------------
   parse_state_e pstate = ST_MAGIC_P;
   int unsigned  acc = 0;           // decimal accumulator of the number being read
   bit           neg = 0;
   bit           have_digit = 0;
   int unsigned  field_idx = 0;     // 0 width, 1 height, 2 maxval
   int unsigned  img_w = 0;
   int unsigned  img_h = 0;
   int unsigned  img_max = 0;
   int unsigned  ncomp_reg = 0;
   int unsigned  col_cnt = 0;
   int unsigned  row_cnt = 0;
   int unsigned  comp_cnt = 0;
   logic [7:0]   hi_byte = '0;
   bit           second_byte = 0;  // high byte of a 16-bit sample is held
   bit           err_stuck = 0;

   parse_result_t pending_results[$];   // predicted rsp transactions, oldest first
   int unsigned   mismatches = 0;
   int unsigned   cycle_count = 0;
   bit            idle_on = 1;          // random idling on both channels

   // Stimulus-side knowledge of the image being sent.
   int unsigned   pic_w, pic_h, pic_max, pic_comps, pic_bytes;

   function automatic bit is_space(input int ch);
      return ch == CH_SP || ch == CH_TAB || ch == CH_LF || ch == CH_CR;
   endfunction

   function automatic int unsigned dim_or_zero();
      if (neg || acc == 0 || acc > DIM_LIMIT) return 0;
      return acc;
   endfunction

   function automatic bit raise_fault(input logic [2:0] code, output parse_result_t r);
      err_stuck = 1'b1;
      r = '0;
      r.kind = KIND_ERROR;
      r.code = code;
      return 1'b1;
   endfunction

   function automatic bit header_done(output parse_result_t r);
      r = '0;
      r.kind   = KIND_HEADER;
      r.width  = img_w[15:0];
      r.height = img_h[15:0];
      r.maxv   = img_max[15:0];
      r.ncomp  = ncomp_reg[1:0];
      return 1'b1;
   endfunction

   // Advances the shadow parser by one byte (or stream end); returns 1 when the
   // block owes a response for it. A phase may hand the byte on to the next one.
   function automatic bit parse_byte(input logic [7:0] b, input bit eos,
                                     output parse_result_t r);
      int          ch;
      bit          stop;
      bit          emit;
      int unsigned value;
      ch = eos ? CH_EOS : int'(b);
      r = '0;
      stop = 1'b0;
      emit = 1'b0;
      if (err_stuck || pstate == ST_DONE) return 1'b0;
      for (int i = 0; i < 8 && !stop; i++) begin
         stop = 1'b1;   // consumed unless the phase hands the byte on
         case (pstate)
            ST_MAGIC_P: begin
               if (ch != CH_P) emit = raise_fault(ERR_MAGIC, r);
               else pstate = ST_MAGIC_DIGIT;
            end
            ST_MAGIC_DIGIT: begin
               if (ch == CH_6) ncomp_reg = 3;
               else if (ch == CH_5) ncomp_reg = 1;
               else emit = raise_fault(ERR_MAGIC, r);
               field_idx = 0;
               pstate = ST_GAP_BLANK;
            end
            ST_GAP_BLANK: begin
               if (ch == CH_LF) pstate = ST_GAP_HASH;
               else if (!(ch == CH_SP || ch == CH_TAB || ch == CH_CR)) begin
                  acc = 0; neg = 0; have_digit = 0;
                  pstate = ST_NUM_LEAD;
                  stop = 1'b0;
               end
            end
            ST_GAP_HASH: begin
               // a comment may only open right after LF or after another comment
               if (ch == CH_HASH) pstate = ST_COMMENT;
               else begin
                  acc = 0; neg = 0; have_digit = 0;
                  pstate = ST_NUM_LEAD;
                  stop = 1'b0;
               end
            end
            ST_COMMENT: begin
               if (ch == CH_LF || ch == CH_CR) pstate = ST_GAP_HASH;
               else if (ch == CH_EOS) begin
                  pstate = ST_GAP_HASH;
                  stop = 1'b0;
               end
            end
            ST_NUM_LEAD: begin
               if (ch == CH_PLUS || ch == CH_MINUS) begin
                  neg = (ch == CH_MINUS);
                  pstate = ST_NUM_SIGN;
               end else if (!is_space(ch)) begin
                  pstate = ST_NUM_DIGITS;
                  stop = 1'b0;
               end
            end
            ST_NUM_SIGN: begin
               if (!is_space(ch)) begin
                  pstate = ST_NUM_DIGITS;
                  stop = 1'b0;
               end
            end
            ST_NUM_DIGITS: begin
               if (ch >= CH_0 && ch <= CH_9) begin
                  if (acc >= ACC_OVF_LIMIT) emit = raise_fault(ERR_OVERFLOW, r);
                  else begin
                     acc = acc * 10 + (ch - CH_0);
                     have_digit = 1'b1;
                  end
               end else if (!have_digit) emit = raise_fault(ERR_NO_DIGITS, r);
               else begin
                  stop = 1'b0;
                  if (field_idx == 0) begin
                     img_w = dim_or_zero();
                     field_idx = 1;
                     pstate = ST_GAP_BLANK;
                  end else if (field_idx == 1) begin
                     img_h = dim_or_zero();
                     field_idx = 2;
                     pstate = ST_GAP_BLANK;
                  end else begin
                     img_max = (neg || acc == 0 || acc > 65535) ? 0 : acc;
                     // range check precedes the separator check
                     if (img_w == 0 || img_h == 0 || img_max == 0) begin
                        emit = raise_fault(ERR_RANGE, r);
                        stop = 1'b1;
                     end else pstate = ST_SEPARATOR;
                  end
               end
            end
            ST_SEPARATOR: begin
               if (ch == CH_SP || ch == CH_LF || ch == CH_TAB) begin
                  pstate = ST_SAMPLES;
                  emit = header_done(r);
               end else if (ch == CH_CR) begin
                  // header goes out on the CR; an LF right after it is swallowed
                  pstate = ST_CRLF;
                  emit = header_done(r);
               end else emit = raise_fault(ERR_SEPARATOR, r);
            end
            ST_CRLF: begin
               pstate = ST_SAMPLES;
               if (ch != CH_LF) stop = 1'b0;   // lone CR: this is a sample byte
            end
            ST_SAMPLES: begin
               if (ch == CH_EOS) emit = raise_fault(ERR_EARLY_END, r);
               else if (img_max > 255 && !second_byte) begin
                  hi_byte = b;
                  second_byte = 1'b1;
               end else begin
                  value = (img_max > 255) ? {16'd0, hi_byte, b} : int'(b);
                  second_byte = 1'b0;
                  if (value > img_max) emit = raise_fault(ERR_PIXEL, r);
                  else begin
                     r.kind   = KIND_SAMPLE;
                     r.sample = value[15:0];
                     r.comp   = comp_cnt[1:0];
                     r.col    = col_cnt[15:0];
                     r.row    = row_cnt[15:0];
                     r.eol    = (comp_cnt + 1 == ncomp_reg) && (col_cnt + 1 == img_w);
                     emit = 1'b1;
                     comp_cnt++;
                     if (comp_cnt >= ncomp_reg) begin
                        comp_cnt = 0;
                        col_cnt++;
                        if (col_cnt >= img_w) begin
                           col_cnt = 0;
                           row_cnt++;
                           if (row_cnt >= img_h) pstate = ST_DONE;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      return emit;
   endfunction

   // ---------------------------------------------------------------------------
   // req side: one byte per transaction, driven on the falling edge. Valid holds
   // until the transaction is taken; random idle gaps drop valid between bytes.
   // ---------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input bit eos);
      parse_result_t r;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_stream <= eos;
      do @(posedge clock); while (!req_ready);
      if (parse_byte(b, eos, r)) pending_results.push_back(r);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   // Decimal number with an optional '+' and blank, plus one leading zero.
   task automatic send_number(input int unsigned v, input bit with_sign);
      if (with_sign) send_text("+ ");
      send_text({"0", $sformatf("%0d", v)});
   endtask

   task automatic send_sample(input int unsigned v);
      if (pic_bytes == 2) send_byte(v[15:8], 1'b0);
      send_byte(v[7:0], 1'b0);
   endtask

   function automatic int unsigned random_sample();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return pic_max;
         default: return $urandom_range(0, pic_max);
      endcase
   endfunction

   // Magic, blanks, comments (one holding high-bit bytes), signed and zero-padded
   // numbers, then one of the separator forms: space, tab, LF, lone CR, CR LF.
   task automatic test_header();
      pic_comps = $urandom_range(0, 1) ? 3 : 1;
      case ($urandom_range(0, 5))
         0: pic_max = 1;
         1: pic_max = 255;
         2: pic_max = 256;
         3: pic_max = 65535;
         4: pic_max = $urandom_range(2, 254);
         default: pic_max = $urandom_range(257, 65534);
      endcase
      pic_bytes = (pic_max > 255) ? 2 : 1;
      pic_w = $urandom_range(0, 4) == 0 ? 1 : $urandom_range(2, 40);
      pic_h = PIXEL_BYTE_BUDGET / (pic_bytes * pic_comps * pic_w);
      if (pic_h == 0) pic_h = 1;

      send_byte(CH_P, 1'b0);
      send_byte(pic_comps == 3 ? CH_6 : CH_5, 1'b0);
      send_text(" \t\r\n#");
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_text("\r");
      send_number(pic_w, 1'b1);
      send_text("\n#h\n");
      send_number(pic_h, 1'b0);
      send_text(" ");
      send_number(pic_max, 1'b0);
      case ($urandom_range(0, 4))
         0: send_text(" ");
         1: send_text("\t");
         2: send_text("\n");
         3: send_text("\r");
         default: send_text("\r\n");
      endcase
   endtask

   // All samples but the last; extremes first, then random values.
   task automatic test_samples();
      int unsigned total;
      total = pic_w * pic_h * pic_comps;
      for (int unsigned i = 0; i + 1 < total; i++) begin
         if (i + CALM_TAIL >= total) idle_on = 1'b0;
         if (i == 0) send_sample(0);
         else if (i == 1) send_sample(pic_max);
         else send_sample(random_sample());
      end
   endtask

   // Close the image one of three ways, then bytes and a stream end that the
   // block must ignore because it is either done or holding an error.
   task automatic test_stream_end();
      stream_end_e how;
      how = stream_end_e'($urandom_range(0, 2));
      if (how == END_BAD_PIXEL && pic_max == 65535) how = END_EARLY;
      if (how == END_BAD_PIXEL && pic_max == 255) how = END_EARLY;
      idle_on = 1'b0;
      case (how)
         END_COMPLETE: send_sample(random_sample());
         END_BAD_PIXEL: send_sample(pic_max + 1);
         default: begin
            // sometimes cut a 16-bit sample in half
            if (pic_bytes == 2 && $urandom_range(0, 1)) send_byte($urandom_range(0, 255), 1'b0);
            send_byte(8'h00, 1'b1);
         end
      endcase
      for (int i = 0; i < 16; i++) send_byte($urandom_range(0, 255), 1'b0);
      send_byte($urandom_range(0, 255), 1'b1);
   endtask

   // rsp side: ready stalls in random bursts while idling is enabled.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic report_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
      $display("%0t: rsp %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
   endtask

   // Every rsp transaction is matched against the oldest prediction.
   always @(posedge clock) begin : rsp_check
      parse_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: rsp transaction with none expected, kind %0d",
                     $time, rsp_result_kind);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_kind !== want.kind)
               report_field("result_kind", want.kind, rsp_result_kind);
            if (rsp_sample_value !== want.sample)
               report_field("sample_value", want.sample, rsp_sample_value);
            if (rsp_component_index !== want.comp)
               report_field("component_index", want.comp, rsp_component_index);
            if (rsp_column !== want.col) report_field("column", want.col, rsp_column);
            if (rsp_row !== want.row) report_field("row", want.row, rsp_row);
            if (rsp_image_width !== want.width)
               report_field("image_width", want.width, rsp_image_width);
            if (rsp_image_height !== want.height)
               report_field("image_height", want.height, rsp_image_height);
            if (rsp_max_value !== want.maxv)
               report_field("max_value", want.maxv, rsp_max_value);
            if (rsp_component_count !== want.ncomp)
               report_field("component_count", want.ncomp, rsp_component_count);
            if (rsp_end_of_line !== want.eol)
               report_field("end_of_line", want.eol, rsp_end_of_line);
            if (rsp_error_code !== want.code)
               report_field("error_code", want.code, rsp_error_code);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("pnm_binary_stream_parser_test: errors");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data_byte     = '0;
      req_end_of_stream = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_header();
      test_samples();
      test_stream_end();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // input and result registers; give stray responses time to show up
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("pnm_binary_stream_parser_test: clean");
      else $display("pnm_binary_stream_parser_test: errors");
      $finish;
   end

endmodule
